// File: hdl/pwt_pkg.sv
// Package for the protobuf wire tokenizer: token type, kind codes, wire type codes,
// length limit and result queue sizing. No dependencies.
package pwt_pkg;

   // Width of the length-delimited byte counter; longer declared lengths are malformed.
   localparam int LENGTH_BITS = 32;
   // Ones in the bits a declared length may use (all ones when LENGTH_BITS is 64).
   localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_BITS) - 64'd1;

   // Result queue: a power of two, at least 2.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_GROUP_S = 3'd3;
   localparam logic [2:0] WT_GROUP_E = 3'd4;
   localparam logic [2:0] WT_FIXED32 = 3'd5;
   localparam logic [2:0] WT_RSVD6   = 3'd6;
   localparam logic [2:0] WT_RSVD7   = 3'd7;

   typedef enum logic [2:0] {
      TK_VARINT  = 3'd0,
      TK_FIXED64 = 3'd1,
      TK_LEN_HDR = 3'd2,
      TK_FIXED32 = 3'd3,
      TK_PAYLOAD = 3'd4,
      TK_END_OK  = 3'd5,
      TK_END_BAD = 3'd6
   } token_kind_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [31:0]    field_number;
      logic [2:0]     wire_type;
      logic [63:0]    token_value;
      logic           payload_end;
      logic           last_token;
   } token_type;

endpackage

// File: hdl/pwt_req_if.sv
// Request channel of the protobuf wire tokenizer: one message byte per request.
// No dependencies.
interface pwt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: hdl/pwt_rsp_if.sv
// Response channel of the protobuf wire tokenizer: one token per transfer.
// No dependencies.
interface pwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [31:0] field_number;
   logic [2:0]  wire_type;
   logic [63:0] token_value;
   logic        payload_end;
   logic        last_token;

   modport source (output valid, output token_kind, output field_number, output wire_type,
                   output token_value, output payload_end, output last_token, input ready);
   modport sink   (input valid, input token_kind, input field_number, input wire_type,
                   input token_value, input payload_end, input last_token, output ready);
endinterface

// File: hdl/pwt_token_queue.sv
// Small token queue: takes zero, one or two tokens a cycle, gives one a cycle when popped.
// Depends on pwt_pkg.
module pwt_token_queue
   import pwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  token_type  push_tok0,
   input  token_type  push_tok1,
   input  logic       pop,
   output token_type  head_tok,
   output logic       not_empty,
   output logic       room
);

   token_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   head_ff, head_in;
   logic [QPTR_BITS-1:0]   tail_ff, tail_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [QPTR_BITS-1:0]   tail_next;

   assign tail_next = tail_ff + QPTR_BITS'(1);
   assign head_tok  = entries_ff[head_ff];
   assign not_empty = (count_ff != '0);
   // room for two tokens, the most one request can cause
   assign room      = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + QPTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + QPTR_BITS'(push_n);
      count_in = count_ff + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[tail_ff] <= push_tok0;
      end
      if (push_n == 2'd2) begin
         entries_ff[tail_next] <= push_tok1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (QCNT_BITS + 1)'(count_ff) + (QCNT_BITS + 1)'(push_n) <= (QCNT_BITS + 1)'(QUEUE_DEPTH)
         + (QCNT_BITS + 1)'(pop))
      else $error("token queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("token queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("token queue count out of range");

endmodule

// File: hdl/protobuf_wire_tokenizer.sv
// protobuf_wire_tokenizer: the tokens of a byte are registered in the token queue that feeds rsp.
// Throughput: a byte is taken every cycle while the four-entry token queue has room for two;
// a byte causing two tokens (a token plus the end token) pushes both; rsp gives them one by one.
// Reset (synchronous, active high) returns the decoder to "expect tag" and empties the queue.
// Depends on pwt_pkg, pwt_req_if, pwt_rsp_if and pwt_token_queue.
module protobuf_wire_tokenizer
   import pwt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   pwt_req_if.sink   req_bus,
   pwt_rsp_if.source rsp_bus
);

   // one-hot decoder phase; malformed is the error phase
   typedef enum logic [3:0] {
      PH_TAG     = 4'b0001,
      PH_VALUE   = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_ERROR   = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [63:0]            acc_ff, acc_in;
   logic [3:0]             shift_ff, shift_in;
   logic [31:0]            field_ff, field_in;
   logic [2:0]             wire_ff, wire_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;

   logic        accept;
   logic [7:0]  data_b;
   logic        fin;
   logic [6:0]  v_amt;
   logic [63:0] v_acc;
   logic        v_done;
   logic        v_over;
   logic [63:0] f_acc;
   logic [3:0]  f_step;
   logic [3:0]  f_need;
   logic        pay_last;

   logic        data_valid;
   token_type   data_tok;
   token_type   end_tok;
   logic [1:0]  push_n;
   token_type   push_tok0;
   logic        q_room;
   logic        q_not_empty;
   token_type   head_tok;
   logic        pop;

   assign accept         = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = q_room;
   assign data_b         = req_bus.data_byte;
   assign fin            = req_bus.final_byte;

   // varint byte: seven bits land at 7*count; bits above 63 fall off
   assign v_amt  = 7'(shift_ff) * 7'd7;
   assign v_acc  = acc_ff | (64'(data_b[6:0]) << v_amt);
   assign v_done = !data_b[7];
   // tenth byte still continuing is overlong
   assign v_over = (shift_ff > 4'd9) || (data_b[7] && (shift_ff == 4'd9));

   // fixed byte: little endian, byte count in the low three bits
   assign f_acc  = acc_ff | (64'(data_b) << {shift_ff[2:0], 3'b000});
   assign f_step = shift_ff + 4'd1;
   assign f_need = (wire_ff == WT_FIXED64) ? 4'd8 : 4'd4;

   assign pay_last = (remain_ff == LENGTH_BITS'(1));

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      shift_in   = shift_ff;
      field_in   = field_ff;
      wire_in    = wire_ff;
      remain_in  = remain_ff;
      data_valid = 1'b0;
      data_tok   = '{token_kind: TK_VARINT, field_number: field_ff, wire_type: wire_ff,
                     token_value: '0, payload_end: 1'b0, last_token: !fin};
      end_tok    = '{token_kind: TK_END_OK, field_number: '0, wire_type: '0,
                     token_value: '0, payload_end: 1'b0, last_token: 1'b1};

      if (accept) begin
         case (phase_ff)
            PH_TAG: begin
               if (v_over) begin
                  phase_in = PH_ERROR;
                  acc_in   = '0;
                  shift_in = '0;
               end else if (v_done) begin
                  field_in = v_acc[34:3];
                  wire_in  = v_acc[2:0];
                  acc_in   = '0;
                  shift_in = '0;
                  if (v_acc[2:0] inside {WT_GROUP_S, WT_GROUP_E, WT_RSVD6, WT_RSVD7}) begin
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end else begin
                  acc_in   = v_acc;
                  shift_in = shift_ff + 4'd1;
               end
            end
            PH_VALUE: begin
               case (wire_ff)
                  WT_VARINT, WT_LEN: begin
                     if (v_over) begin
                        phase_in = PH_ERROR;
                        acc_in   = '0;
                        shift_in = '0;
                     end else if (v_done) begin
                        acc_in   = '0;
                        shift_in = '0;
                        if (wire_ff == WT_VARINT) begin
                           data_valid           = 1'b1;
                           data_tok.token_kind  = TK_VARINT;
                           data_tok.wire_type   = WT_VARINT;
                           data_tok.token_value = v_acc;
                           phase_in             = PH_TAG;
                        end else if ((v_acc & ~LEN_MASK) != 64'd0) begin
                           // declared length too wide for the counter
                           phase_in = PH_ERROR;
                        end else begin
                           data_valid           = 1'b1;
                           data_tok.token_kind  = TK_LEN_HDR;
                           data_tok.wire_type   = WT_LEN;
                           data_tok.token_value = v_acc;
                           remain_in            = v_acc[LENGTH_BITS-1:0];
                           // zero length goes straight back to the next tag
                           phase_in = (v_acc != 64'd0) ? PH_PAYLOAD : PH_TAG;
                        end
                     end else begin
                        acc_in   = v_acc;
                        shift_in = shift_ff + 4'd1;
                     end
                  end
                  WT_FIXED64, WT_FIXED32: begin
                     acc_in   = f_acc;
                     shift_in = f_step;
                     if (f_step >= f_need) begin
                        data_valid           = 1'b1;
                        data_tok.token_kind  = (wire_ff == WT_FIXED64) ? TK_FIXED64 : TK_FIXED32;
                        data_tok.token_value = f_acc;
                        acc_in               = '0;
                        shift_in             = '0;
                        phase_in             = PH_TAG;
                     end
                  end
                  default: begin
                     phase_in = PH_ERROR;
                     acc_in   = '0;
                     shift_in = '0;
                  end
               endcase
            end
            PH_PAYLOAD: begin
               remain_in            = remain_ff - LENGTH_BITS'(1);
               data_valid           = 1'b1;
               data_tok.token_kind  = TK_PAYLOAD;
               data_tok.wire_type   = WT_LEN;
               data_tok.token_value = 64'(data_b);
               data_tok.payload_end = pay_last;
               if (pay_last) begin
                  phase_in = PH_TAG;
               end
            end
            PH_ERROR: begin
               // silent until the final byte
            end
            default: begin
               phase_in = PH_ERROR;
               acc_in   = '0;
               shift_in = '0;
            end
         endcase

         if (fin) begin
            // clean end only between fields with no tag bytes pending
            if ((phase_in != PH_TAG) || (shift_in != 4'd0)) begin
               end_tok.token_kind = TK_END_BAD;
            end
            phase_in  = PH_TAG;
            acc_in    = '0;
            shift_in  = '0;
            field_in  = '0;
            wire_in   = '0;
            remain_in = '0;
         end
      end

      push_n    = accept ? (2'(data_valid) + 2'(fin)) : 2'd0;
      push_tok0 = data_valid ? data_tok : end_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         acc_ff    <= '0;
         shift_ff  <= '0;
         field_ff  <= '0;
         wire_ff   <= '0;
         remain_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         shift_ff  <= shift_in;
         field_ff  <= field_in;
         wire_ff   <= wire_in;
         remain_ff <= remain_in;
      end
   end

   // tokens wait here so new bytes keep coming while rsp stalls
   pwt_token_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_tok0 (push_tok0),
      .push_tok1 (end_tok),
      .pop       (pop),
      .head_tok  (head_tok),
      .not_empty (q_not_empty),
      .room      (q_room)
   );

   assign pop                  = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid        = q_not_empty;
   assign rsp_bus.token_kind   = head_tok.token_kind;
   assign rsp_bus.field_number = head_tok.field_number;
   assign rsp_bus.wire_type    = head_tok.wire_type;
   assign rsp_bus.token_value  = head_tok.token_value;
   assign rsp_bus.payload_end  = head_tok.payload_end;
   assign rsp_bus.last_token   = head_tok.last_token;

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && fin) |=> (phase_ff == PH_TAG) && (shift_ff == 4'd0) && (acc_ff == 64'd0))
      else $error("final byte did not return decoder to tag phase");

   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_PAYLOAD)) |-> data_valid)
      else $error("payload byte produced no token");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_ERROR) && !fin) |-> (push_n == 2'd0))
      else $error("token emitted after malformed input");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      shift_ff <= 4'd9)
      else $error("byte count out of range");

endmodule

// File: tb/sv/pwt_token_checker.sv
// Token checker for the protobuf wire tokenizer. It decodes every accepted request byte
// on its own and matches each response token, field by field, against the oldest prediction.
// Depends on pwt_pkg, pwt_req_if and pwt_rsp_if.
module pwt_token_checker
   import pwt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pwt_req_if   req,
   pwt_rsp_if   rsp,
   output int   fail_count,
   output int   pending
);

   typedef enum logic [1:0] {SEEK_TAG, SEEK_VALUE, IN_PAYLOAD, SKIP_ALL} parse_state_type;

   parse_state_type        state     = SEEK_TAG;
   logic [63:0]            acc       = '0;
   logic [3:0]             step      = '0;
   logic [31:0]            field     = '0;
   logic [2:0]             cur_wire  = '0;
   logic [LENGTH_BITS-1:0] remaining = '0;
   logic                   bad       = 1'b0;

   token_type tokens_due[$];

   function automatic void clear_decoder();
      state     = SEEK_TAG;
      acc       = '0;
      step      = '0;
      field     = '0;
      cur_wire  = '0;
      remaining = '0;
      bad       = 1'b0;
   endfunction

   function automatic void enter_error();
      bad   = 1'b1;
      state = SKIP_ALL;
      acc   = '0;
      step  = '0;
   endfunction

   // -1 overlong, 0 more bytes follow, 1 complete
   function automatic int take_varint(input logic [7:0] b);
      if (step > 9) return -1;
      acc |= {57'd0, b[6:0]} << (7 * step);
      if (!b[7]) return 1;
      step++;
      return (step >= 10) ? -1 : 0;
   endfunction

   function automatic void queue_token(input token_kind_type kind, input logic [31:0] fnum,
                                       input logic [2:0] wt, input logic [63:0] value,
                                       input logic pend);
      token_type t;
      t.token_kind   = kind;
      t.field_number = fnum;
      t.wire_type    = wt;
      t.token_value  = value;
      t.payload_end  = pend;
      t.last_token   = 1'b0;
      tokens_due.push_back(t);
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic fin);
      int          queued_at_start;
      int          v;
      logic [63:0] val;
      queued_at_start = tokens_due.size();
      if (!bad) begin
         case (state)
            SEEK_TAG: begin
               v = take_varint(b);
               if (v < 0) begin
                  enter_error();
               end else if (v > 0) begin
                  field    = acc[34:3];
                  cur_wire = acc[2:0];
                  acc      = '0;
                  step     = '0;
                  if (cur_wire == WT_GROUP_S || cur_wire == WT_GROUP_E ||
                      cur_wire == WT_RSVD6 || cur_wire == WT_RSVD7)
                     enter_error();
                  else
                     state = SEEK_VALUE;
               end
            end
            SEEK_VALUE: begin
               if (cur_wire == WT_VARINT || cur_wire == WT_LEN) begin
                  v = take_varint(b);
                  if (v < 0) begin
                     enter_error();
                  end else if (v > 0) begin
                     val  = acc;
                     acc  = '0;
                     step = '0;
                     if (cur_wire == WT_VARINT) begin
                        queue_token(TK_VARINT, field, WT_VARINT, val, 1'b0);
                        state = SEEK_TAG;
                     end else if ((val & ~LEN_MASK) != 0) begin
                        enter_error();
                     end else begin
                        queue_token(TK_LEN_HDR, field, WT_LEN, val, 1'b0);
                        remaining = val[LENGTH_BITS-1:0];
                        state     = (val != 0) ? IN_PAYLOAD : SEEK_TAG;
                     end
                  end
               end else if (cur_wire == WT_FIXED64 || cur_wire == WT_FIXED32) begin
                  acc  |= {56'd0, b} << (8 * step[2:0]);
                  step  = step + 4'd1;
                  if (step >= ((cur_wire == WT_FIXED64) ? 8 : 4)) begin
                     if (cur_wire == WT_FIXED64)
                        queue_token(TK_FIXED64, field, cur_wire, acc, 1'b0);
                     else
                        queue_token(TK_FIXED32, field, cur_wire, acc, 1'b0);
                     acc   = '0;
                     step  = '0;
                     state = SEEK_TAG;
                  end
               end else begin
                  enter_error();
               end
            end
            IN_PAYLOAD: begin
               remaining = remaining - 1'b1;
               queue_token(TK_PAYLOAD, field, WT_LEN, {56'd0, b}, remaining == 0);
               if (remaining == 0) state = SEEK_TAG;
            end
            default: enter_error();
         endcase
      end
      if (fin) begin
         if (!bad && state == SEEK_TAG && step == 0)
            queue_token(TK_END_OK, '0, '0, '0, 1'b0);
         else
            queue_token(TK_END_BAD, '0, '0, '0, 1'b0);
         clear_decoder();
      end
      if (tokens_due.size() > queued_at_start)
         tokens_due[tokens_due.size() - 1].last_token = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         clear_decoder();
         tokens_due.delete();
         fail_count = 0;
      end else begin
         // prediction first, so a same-edge response still finds its entry
         if (req.valid && req.ready) decode_byte(req.data_byte, req.final_byte);
         if (rsp.valid && rsp.ready) begin
            if (tokens_due.size() == 0) begin
               $error("token with nothing expected: kind %0d, value %0h",
                      rsp.token_kind, rsp.token_value);
               fail_count++;
            end else begin
               want = tokens_due.pop_front();
               check_field("token_kind", 64'(want.token_kind), 64'(rsp.token_kind));
               check_field("field_number", 64'(want.field_number), 64'(rsp.field_number));
               check_field("wire_type", 64'(want.wire_type), 64'(rsp.wire_type));
               check_field("token_value", want.token_value, rsp.token_value);
               check_field("payload_end", 64'(want.payload_end), 64'(rsp.payload_end));
               check_field("last_token", 64'(want.last_token), 64'(rsp.last_token));
            end
         end
      end
      pending = tokens_due.size();
   end

endmodule

// File: tb/sv/protobuf_wire_tokenizer_test.sv
// Top of the protobuf wire tokenizer test: clock, reset, request and response stimulus,
// and the final verdict. Checking lives in pwt_token_checker.
// Depends on pwt_pkg, pwt_req_if, pwt_rsp_if, pwt_token_checker and the tokenizer RTL.
module protobuf_wire_tokenizer_test
   import pwt_pkg::*;
();

   // Far above any correct run: ~450 bytes, two tokens per byte at most, with heavy stalls.
   localparam int LIMIT_CYCLES     = 200000;
   localparam int BYTES_PER_PHASE  = 100;
   localparam int DRAIN_CYCLES     = 20;
   localparam int DIRECTED_LEN     = 23;

   localparam logic [2:0] BAD_WIRES [4] = '{WT_GROUP_S, WT_GROUP_E, WT_RSVD6, WT_RSVD7};

   // Directed bytes, bit 8 marks the final byte of a message.
   localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
      9'h008, 9'h096, 9'h001,                 // varint 150 on field 1
      9'h012, 9'h001, 9'h0AB,                 // one payload byte, payload_end set
      9'h01A, 9'h100,                         // zero length on the final byte: header + end
      9'h00B, 9'h055, 9'h100,                 // group start wire type, then silence
      9'h10C,                                 // group end wire type on the final byte
      9'h10E,                                 // reserved wire type 6
      9'h10F,                                 // reserved wire type 7
      9'h108,                                 // message ends right after a tag
      9'h015, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF, // fixed32 all ones, then end ok
      9'h022, 9'h002, 9'h101                  // payload cut short by the final byte
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int bytes_sent     = 0;
   int cycles         = 0;
   int fail_count;
   int pending;

   logic [7:0] msg_bytes[$];

   pwt_req_if req_bus ();
   pwt_rsp_if rsp_bus ();

   protobuf_wire_tokenizer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pwt_token_checker token_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $error("timeout after %0d cycles, %0d tokens still due", cycles, pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Response side back-pressure, redrawn every cycle at the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request: optional idle cycles, then hold valid until the DUT takes it.
   // Valid stays high on return so back-to-back requests never toggle it within a step.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.final_byte <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Mostly minimal encodings; now and then padded with redundant 0x80 groups.
   function automatic int varint_pad();
      return ($urandom_range(5) == 0) ? $urandom_range(2, 10) : 1;
   endfunction

   // Values spread over every bit length, with the all-zero and all-one extremes.
   function automatic logic [63:0] any_value();
      logic [63:0] v;
      int          k;
      v = {$urandom, $urandom};
      k = $urandom_range(64);
      case ($urandom_range(9))
         0:       v = '0;
         1:       v = '1;
         default: if (k < 64) v = v & ((64'd1 << k) - 64'd1);
      endcase
      return v;
   endfunction

   task automatic append_varint(input logic [63:0] v, input int min_len);
      int   count;
      logic more;
      count = 0;
      do begin
         count++;
         more = ((v >> 7) != 0) || (count < min_len);
         msg_bytes.push_back({more, v[6:0]});
         v = v >> 7;
      end while (more);
   endtask

   // Field numbers hit 0, all ones and random 32-bit values; sometimes the tag
   // carries bits above the field number, which the block must drop.
   task automatic add_tag(input logic [2:0] wt);
      logic [31:0] fnum;
      logic [63:0] tag;
      case ($urandom_range(4))
         0:       fnum = '0;
         1:       fnum = '1;
         2:       fnum = $urandom;
         3:       fnum = $urandom_range(16, 2047);
         default: fnum = $urandom_range(1, 15);
      endcase
      tag = {29'd0, fnum, wt};
      if ($urandom_range(9) == 0) tag[63:35] = 29'($urandom);
      append_varint(tag, varint_pad());
   endtask

   task automatic add_clean_field();
      logic [63:0] v;
      int          len;
      v = any_value();
      case ($urandom_range(3))
         0: begin
            add_tag(WT_VARINT);
            append_varint(v, varint_pad());
         end
         1: begin
            add_tag(WT_FIXED64);
            for (int i = 0; i < 8; i++) msg_bytes.push_back(v[8*i +: 8]);
         end
         2: begin
            add_tag(WT_FIXED32);
            for (int i = 0; i < 4; i++) msg_bytes.push_back(v[8*i +: 8]);
         end
         default: begin
            // short payloads keep most messages quick; a few longer ones
            len = ($urandom_range(9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
            add_tag(WT_LEN);
            append_varint(64'(len), varint_pad());
            repeat (len) msg_bytes.push_back(8'($urandom));
         end
      endcase
   endtask

   // Builds one message: mostly well formed, some cut short, some with a defect
   // in the middle (later fields must stay silent), some plain noise.
   task automatic compose_message();
      int          pick;
      int          k;
      logic [63:0] val;
      msg_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 64) begin
         repeat ($urandom_range(1, 4)) add_clean_field();
      end else if (pick < 78) begin
         repeat ($urandom_range(1, 3)) add_clean_field();
         if (msg_bytes.size() > 1) begin
            k = $urandom_range(1, msg_bytes.size() - 1);
            msg_bytes = msg_bytes[0:k-1];
         end
      end else if (pick < 90) begin
         repeat ($urandom_range(0, 2)) add_clean_field();
         case ($urandom_range(3))
            0: begin
               add_tag(BAD_WIRES[$urandom_range(3)]);
               repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
            end
            // ten continuation bytes: overlong tag
            1: repeat (10) msg_bytes.push_back(8'h80 | 8'($urandom));
            // ten continuation bytes: overlong varint value
            2: begin
               add_tag(WT_VARINT);
               repeat (10) msg_bytes.push_back(8'h80 | 8'($urandom));
            end
            default: begin
               // declared length wider than the length counter
               add_tag(WT_LEN);
               val = {$urandom, $urandom};
               if (LENGTH_BITS < 64) val[$urandom_range(63, LENGTH_BITS)] = 1'b1;
               append_varint(val, 1);
            end
         endcase
         repeat ($urandom_range(0, 2)) add_clean_field();
      end else begin
         repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      end
   endtask

   initial begin
      int target;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.final_byte = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corner cases, no idling.
      for (int i = 0; i < DIRECTED_LEN; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

      // Random messages in four pressure phases: none, sender gaps, receiver
      // stalls, then both at a lighter rate.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         target = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < target) begin
            compose_message();
            foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
         end
      end
      req_bus.valid <= 1'b0;

      // Drain: every predicted token must come out, then a quiet window
      // catches any stray extra token.
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/pwt_pkg.sv
hdl/pwt_req_if.sv
hdl/pwt_rsp_if.sv
hdl/pwt_token_queue.sv
hdl/protobuf_wire_tokenizer.sv
tb/sv/pwt_token_checker.sv
tb/sv/protobuf_wire_tokenizer_test.sv
